// ===== hw/rtl/gpc_pkg.sv =====
package gpc_pkg;

	localparam int MAX_GRID = 512;
	localparam int IDX_W    = $clog2(MAX_GRID);
	localparam int SIZE_W   = 10;
	localparam int COST_W   = 16;
	localparam int VAL_W    = 27;
	localparam int OUT_W    = 26;
	localparam int CFG_W    = 10;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_DATA_W = 48;

	localparam logic [SIZE_W-1:0]    GRID_SIZE_RESET = SIZE_W'(256);
	localparam logic [SIZE_W-1:0]    GRID_SIZE_MAX   = SIZE_W'(MAX_GRID);
	localparam logic [VAL_W-1:0]     VAL_MAX         = {VAL_W{1'b1}};
	localparam logic [OUT_W-1:0]     OUT_MAX         = {OUT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_MAXIMUM = 1'b1;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  column;
		logic              has_below;
		logic              has_right;
		logic              done;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/grid_path_cost_dp.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[15:0] = cell_cost
// m_*      out  m_tvalid/m_tready  m_tdata = path_value, row_index, column_index; m_tlast = grid_done
// cfg_*    in   cfg_we             cfg_index selects grid_size (0) or use_maximum (1), cfg_data
//
// One item per cycle sustained while m_tready is high; each item passes the line store
// read in the accept cycle, then the add, compare and write-back in the second stage.
// A cell reads the line store entry written by its lower neighbour n items earlier,
// which has always left the add stage by then, so no forwarding is needed.
// Reset clears control state only; the line store is never cleared, as the bottom row
// of every grid writes it before any row above reads it.
// The output register and the add stage keep accepting while m_tready is low until both hold an item.
module grid_path_cost_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gpc_pkg::COST_W-1:0]       s_tdata,   // [15:0] cell_cost
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gpc_pkg::OUT_DATA_W-1:0]   m_tdata,   // [25:0] path_value, [34:26] row_index,
	                                                    // [43:35] column_index, [47:44] zero
	output logic                             m_tlast,   // grid_done
	input  logic                             cfg_we,
	input  logic [gpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpc_pkg::CFG_W-1:0]        cfg_data
);

	logic [gpc_pkg::SIZE_W-1:0] grid_size_q;
	logic                       use_maximum_q;
	logic [gpc_pkg::IDX_W-1:0]  current_row_q;
	logic [gpc_pkg::IDX_W-1:0]  current_column_q;
	logic [gpc_pkg::VAL_W-1:0]  right_q;

	logic [gpc_pkg::VAL_W-1:0]  line_mem [gpc_pkg::MAX_GRID];
	logic [gpc_pkg::VAL_W-1:0]  below_s1;

	logic                       valid_s1;
	gpc_pkg::cell_ctl_t         ctl_s1;

	logic                       out_valid_q;
	logic [gpc_pkg::OUT_W-1:0]  out_value_q;
	logic [gpc_pkg::IDX_W-1:0]  out_row_q;
	logic [gpc_pkg::IDX_W-1:0]  out_column_q;
	logic                       out_done_q;

	logic [gpc_pkg::SIZE_W-1:0] size_m1;
	logic [gpc_pkg::IDX_W-1:0]  last_idx;
	logic                       accept;
	logic                       adv_s1;
	logic                       grid_write;
	gpc_pkg::cell_ctl_t         ctl_in;
	logic [gpc_pkg::VAL_W-1:0]  pick;
	logic [gpc_pkg::VAL_W:0]    sum;
	logic [gpc_pkg::VAL_W-1:0]  val;

	// Effective grid size minus one: zero acts as one, anything above the store depth as the depth.
	always_comb begin
		size_m1 = grid_size_q - gpc_pkg::SIZE_W'(1);
		priority if (grid_size_q == '0) begin
			last_idx = '0;
		end else if (grid_size_q > gpc_pkg::GRID_SIZE_MAX) begin
			last_idx = gpc_pkg::IDX_W'(gpc_pkg::MAX_GRID - 1);
		end else begin
			last_idx = size_m1[gpc_pkg::IDX_W-1:0];
		end
	end

	assign adv_s1     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || adv_s1;
	assign accept     = s_tvalid && s_tready;
	assign grid_write = cfg_we && (cfg_index == gpc_pkg::REG_GRID_SIZE);

	always_comb begin
		ctl_in.cost      = s_tdata;
		ctl_in.row       = current_row_q;
		ctl_in.column    = current_column_q;
		ctl_in.has_below = (current_row_q != last_idx);
		ctl_in.has_right = (current_column_q != last_idx);
		ctl_in.done      = (current_row_q == '0) && (current_column_q == '0);
	end

	// Second stage: better neighbour, add and saturate.
	always_comb begin
		priority if (ctl_s1.has_below && ctl_s1.has_right) begin
			if (use_maximum_q) begin
				pick = (below_s1 > right_q) ? below_s1 : right_q;
			end else begin
				pick = (below_s1 < right_q) ? below_s1 : right_q;
			end
		end else if (ctl_s1.has_below) begin
			pick = below_s1;
		end else if (ctl_s1.has_right) begin
			pick = right_q;
		end else begin
			pick = '0;
		end
		sum = {1'b0, pick} + (gpc_pkg::VAL_W + 1)'(ctl_s1.cost);
		val = sum[gpc_pkg::VAL_W] ? gpc_pkg::VAL_MAX : sum[gpc_pkg::VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q      <= gpc_pkg::GRID_SIZE_RESET;
			use_maximum_q    <= 1'b0;
			current_row_q    <= gpc_pkg::IDX_W'(gpc_pkg::GRID_SIZE_RESET - gpc_pkg::SIZE_W'(1));
			current_column_q <= gpc_pkg::IDX_W'(gpc_pkg::GRID_SIZE_RESET - gpc_pkg::SIZE_W'(1));
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gpc_pkg::REG_GRID_SIZE:   grid_size_q   <= cfg_data;
					gpc_pkg::REG_USE_MAXIMUM: use_maximum_q <= cfg_data[0];
				endcase
			end
			priority if (grid_write) begin
				// Restart at the bottom-right cell of the new size.
				priority if (cfg_data == '0) begin
					current_row_q    <= '0;
					current_column_q <= '0;
				end else if (cfg_data > gpc_pkg::GRID_SIZE_MAX) begin
					current_row_q    <= gpc_pkg::IDX_W'(gpc_pkg::MAX_GRID - 1);
					current_column_q <= gpc_pkg::IDX_W'(gpc_pkg::MAX_GRID - 1);
				end else begin
					current_row_q    <= gpc_pkg::IDX_W'(cfg_data - gpc_pkg::CFG_W'(1));
					current_column_q <= gpc_pkg::IDX_W'(cfg_data - gpc_pkg::CFG_W'(1));
				end
			end else if (accept) begin
				if (current_column_q == '0) begin
					current_column_q <= last_idx;
					current_row_q    <= (current_row_q == '0) ? last_idx
					                                          : current_row_q - gpc_pkg::IDX_W'(1);
				end else begin
					current_column_q <= current_column_q - gpc_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			right_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (grid_write) begin
				right_q <= '0;
			end else if (adv_s1) begin
				right_q <= val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_in;
		end
		if (adv_s1) begin
			out_value_q  <= (val > gpc_pkg::VAL_W'(gpc_pkg::OUT_MAX)) ? gpc_pkg::OUT_MAX
			                                                          : val[gpc_pkg::OUT_W-1:0];
			out_row_q    <= ctl_s1.row;
			out_column_q <= ctl_s1.column;
			out_done_q   <= ctl_s1.done;
		end
	end

	// Line store: one entry per column, read at accept, written back when the cell leaves stage one.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			line_mem[ctl_s1.column] <= val;
		end
		if (accept) begin
			below_s1 <= line_mem[current_column_q];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_column_q, out_row_q, out_value_q};
	assign m_tlast  = out_done_q;

	a_last_is_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (out_row_q == '0) && (out_column_q == '0))
		else $error("grid_done on a cell other than the top-left one");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("stage one item dropped while stalled");

	a_counters_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(current_row_q <= last_idx) && (current_column_q <= last_idx))
		else $error("cell counters outside the grid");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(valid_s1 && out_valid_q && !m_tready))
		else $error("input ready while both stages are full and stalled");

endmodule
